// ----- design/bvs_pkg.sv -----
`timescale 1ns / 1ps

package bvs_pkg;

	localparam int MAX_BITS_DEF  = 1024;
	localparam int WORD_BITS_DEF = 32;

	localparam int CMD_W   = 4;
	localparam int FIELD_W = 11;
	localparam int ST_W    = 2;

	localparam logic [CMD_W-1:0] CMD_PUSH      = 4'd0;
	localparam logic [CMD_W-1:0] CMD_POP       = 4'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK      = 4'd2;
	localparam logic [CMD_W-1:0] CMD_SET_BIT   = 4'd3;
	localparam logic [CMD_W-1:0] CMD_CLR_BIT   = 4'd4;
	localparam logic [CMD_W-1:0] CMD_SET_RANGE = 4'd5;
	localparam logic [CMD_W-1:0] CMD_CLR_RANGE = 4'd6;
	localparam logic [CMD_W-1:0] CMD_SET_ALL   = 4'd7;
	localparam logic [CMD_W-1:0] CMD_CLR_ALL   = 4'd8;
	localparam logic [CMD_W-1:0] CMD_RESIZE    = 4'd9;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic               bit_value;
		logic [FIELD_W-1:0] position;
		logic [FIELD_W-1:0] count;
	} bvs_req_t;

	typedef struct packed {
		logic               read_bit;
		logic [FIELD_W-1:0] current_length;
		logic [ST_W-1:0]    status;
	} bvs_rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_MODIFY,
		S_RESP
	} bvs_state_t;

endpackage

// ----- design/bvs_chan_if.sv -----
`timescale 1ns / 1ps

interface bvs_chan_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

// ----- design/bit_vector_store.sv -----
`timescale 1ns / 1ps

// Channel    Modport  Payload    Role
// request    sink     bvs_req_t  one command per item
// response   source   bvs_rsp_t  one result per command
//
// After reset a clearing pass writes zeros to every RAM word, one word per cycle
// (ceil(MAX_BITS / word width) words), and request.ready stays low meanwhile.
// A command that touches no RAM word goes straight from S_IDLE to S_RESP.
// A command that touches memory reads each word of its bit range in S_READ and writes
// it back in S_MODIFY (PEEK writes nothing), then S_RESP loads the result register.
// The result register holds until taken. A new item may be accepted meanwhile, and
// its result waits in the last state, with request.ready low, until the register frees.

module bit_vector_store #(
	parameter int MAX_BITS  = bvs_pkg::MAX_BITS_DEF,
	parameter int WORD_BITS = bvs_pkg::WORD_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	bvs_chan_if.sink       request,
	bvs_chan_if.source     response
);

	import bvs_pkg::*;

	// The RAM word is the largest power of two not above WORD_BITS.
	localparam int OFF   = $clog2(WORD_BITS + 1) - 1;
	localparam int WB    = 1 << OFF;
	localparam int DEPTH = (MAX_BITS + WB - 1) / WB;
	localparam int WAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW    = $clog2(MAX_BITS + 1);
	localparam int XW    = ((LW > FIELD_W) ? LW : FIELD_W) + 1;

	bvs_state_t state_q, state_d;

	logic [WAW-1:0]     w_q;
	logic [LW-1:0]      len_q;
	logic               out_valid_q;
	bvs_rsp_t           out_q;
	logic [XW-1:0]      lo_q, last_q;
	logic               v_q, wr_q, rd_q, rd_bit_q;
	logic [FIELD_W-1:0] res_len_q;
	logic [ST_W-1:0]    res_st_q;

	logic [XW-1:0]   pos_x, cnt_x, len_x, max_x, end_x;
	logic [XW-1:0]   dec_lo, dec_last, dec_len;
	logic            dec_v, dec_wr, dec_rd, dec_mem;
	logic [ST_W-1:0] dec_st;

	logic            ram_we;
	logic [WAW-1:0]  ram_addr;
	logic [WB-1:0]   ram_wdata, ram_rdata;
	logic [WB-1:0]   ones, mask, new_word;
	logic [OFF-1:0]  lo_off, last_off;
	logic [WAW-1:0]  lo_w, last_w;
	logic            take_out;

	bvs_ram #(
		.WIDTH (WB),
		.DEPTH (DEPTH),
		.AW    (WAW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	assign pos_x = XW'(request.data.position);
	assign cnt_x = XW'(request.data.count);
	assign len_x = XW'(len_q);
	assign max_x = XW'(MAX_BITS);
	assign end_x = pos_x + cnt_x;

	always_comb begin
		dec_lo   = '0;
		dec_last = '0;
		dec_len  = len_x;
		dec_v    = 1'b0;
		dec_wr   = 1'b1;
		dec_rd   = 1'b0;
		dec_mem  = 1'b0;
		dec_st   = ST_OK;
		case (request.data.command)
			CMD_PUSH: begin
				if (len_x >= max_x) begin
					dec_st = ST_FULL;
				end else begin
					dec_lo   = len_x;
					dec_last = len_x;
					dec_v    = request.data.bit_value;
					dec_len  = len_x + XW'(1);
					dec_mem  = 1'b1;
				end
			end
			CMD_POP: begin
				if (len_x != '0) begin
					dec_lo   = len_x - XW'(1);
					dec_last = len_x - XW'(1);
					dec_len  = len_x - XW'(1);
					dec_rd   = 1'b1;
					dec_mem  = 1'b1;
				end
			end
			CMD_PEEK: begin
				if (pos_x >= max_x) begin
					dec_st = ST_FULL;
				end else begin
					dec_lo   = pos_x;
					dec_last = pos_x;
					dec_wr   = 1'b0;
					dec_rd   = 1'b1;
					dec_mem  = 1'b1;
				end
			end
			CMD_SET_BIT, CMD_CLR_BIT: begin
				if (pos_x >= max_x) begin
					dec_st = ST_FULL;
				end else begin
					dec_lo   = pos_x;
					dec_last = pos_x;
					dec_v    = (request.data.command == CMD_SET_BIT);
					dec_mem  = 1'b1;
					if (pos_x >= len_x) begin
						dec_len = pos_x + XW'(1);
					end
				end
			end
			CMD_SET_RANGE, CMD_CLR_RANGE: begin
				if (cnt_x != '0) begin
					if (end_x > max_x) begin
						dec_st = ST_FULL;
					end else begin
						dec_lo   = pos_x;
						dec_last = end_x - XW'(1);
						dec_v    = (request.data.command == CMD_SET_RANGE);
						dec_mem  = 1'b1;
						if (end_x > len_x) begin
							dec_len = end_x;
						end
					end
				end
			end
			CMD_SET_ALL, CMD_CLR_ALL: begin
				if (len_x != '0) begin
					dec_lo   = '0;
					dec_last = len_x - XW'(1);
					dec_v    = (request.data.command == CMD_SET_ALL);
					dec_mem  = 1'b1;
				end
			end
			CMD_RESIZE: begin
				if (cnt_x == '0) begin
					dec_st = ST_BAD;
				end else if (cnt_x > max_x) begin
					dec_st = ST_FULL;
				end else begin
					dec_len = cnt_x;
					if (cnt_x < len_x) begin
						dec_lo   = cnt_x;
						dec_last = len_x - XW'(1);
						dec_mem  = 1'b1;
					end
				end
			end
			default: begin
				dec_st = ST_BAD;
			end
		endcase
	end

	assign ones     = '1;
	assign lo_off   = lo_q[OFF-1:0];
	assign last_off = last_q[OFF-1:0];
	assign lo_w     = lo_q[OFF +: WAW];
	assign last_w   = last_q[OFF +: WAW];
	assign mask     = ((w_q == lo_w) ? (ones << lo_off) : ones)
			& ((w_q == last_w) ? (ones >> (~last_off)) : ones);
	assign new_word = v_q ? (ram_rdata | mask) : (ram_rdata & ~mask);
	assign take_out = !out_valid_q || response.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (w_q == WAW'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (request.valid) begin
					state_d = dec_mem ? S_READ : S_RESP;
				end
			end
			S_READ: begin
				state_d = S_MODIFY;
			end
			S_MODIFY: begin
				state_d = (w_q == last_w) ? S_RESP : S_READ;
			end
			S_RESP: begin
				if (take_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		request.ready = (state_q == S_IDLE);
		ram_addr      = w_q;
		ram_we        = 1'b0;
		ram_wdata     = new_word;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			S_MODIFY: begin
				ram_we = wr_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign response.valid = out_valid_q;
	assign response.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			w_q         <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_RESP && take_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && response.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					w_q <= w_q + WAW'(1);
				end
				S_IDLE: begin
					if (request.valid) begin
						w_q   <= dec_lo[OFF +: WAW];
						len_q <= dec_len[LW-1:0];
					end
				end
				S_MODIFY: begin
					w_q <= w_q + WAW'(1);
				end
				default: begin
					w_q <= w_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && request.valid) begin
			lo_q      <= dec_lo;
			last_q    <= dec_last;
			v_q       <= dec_v;
			wr_q      <= dec_wr;
			rd_q      <= dec_rd;
			rd_bit_q  <= 1'b0;
			res_len_q <= FIELD_W'(dec_len);
			res_st_q  <= dec_st;
		end
		if (state_q == S_MODIFY && rd_q) begin
			rd_bit_q <= ram_rdata[lo_off];
		end
		if (state_q == S_RESP && take_out) begin
			out_q.read_bit       <= rd_bit_q;
			out_q.current_length <= res_len_q;
			out_q.status         <= res_st_q;
		end
	end

endmodule

// ----- design/bvs_ram.sv -----
`timescale 1ns / 1ps

module bvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
